// ===== rtl/core/itcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Interval timer counter channel package
// Shared widths, item codes and control word values for the counter channel.
// ----------------------------------------------------------------------------
package itcc_pkg;

   // Field widths.
   localparam int OP_W    = 2;
   localparam int PORT_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 16;

   // Item kinds.
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Bus ports.
   localparam logic [PORT_W-1:0] PORT_DATA = 2'd0;
   localparam logic [PORT_W-1:0] PORT_CTRL = 2'd1;
   localparam logic [PORT_W-1:0] PORT_SYS  = 2'd2;

   // Control words that the channel understands.
   localparam logic [BYTE_W-1:0] CW_SQUARE  = 8'hb6;
   localparam logic [BYTE_W-1:0] CW_ONESHOT = 8'hb2;
   localparam logic [BYTE_W-1:0] CW_LATCH   = 8'hd8;

   // System control port bits.
   localparam int SYS_GATE_BIT = 0;
   localparam int SYS_SPK_BIT  = 1;
   localparam int SYS_OUT_BIT  = 5;

endpackage : itcc_pkg

// ===== rtl/core/interval_timer_counter_channel_core.sv =====
// ----------------------------------------------------------------------------
// Interval timer counter channel core
// One binary 16-bit counter channel in mode 3 (square wave) or mode 1
// (gate-triggered one-shot), with the system control port for gate and
// speaker enable.
// ----------------------------------------------------------------------------
// The channel takes one item per clock while the request side is not stalled: a
// tick, a bus write or a bus read. Every item produces exactly one result,
// passing first through the input register and then the result register, with
// all counter and bus logic in between. A stalled result holds the input
// register, so the request side stalls only when both registers are full.
// There is no clearing pass after reset.
module interval_timer_counter_channel_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [itcc_pkg::OP_W-1:0]    req_op,
   input  logic [itcc_pkg::PORT_W-1:0]  req_port,
   input  logic [itcc_pkg::BYTE_W-1:0]  req_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [itcc_pkg::BYTE_W-1:0]  rsp_rdata,
   output logic                         rsp_out_level,
   output logic                         rsp_speaker
);
   import itcc_pkg::*;

   // Input register.
   logic                in_valid_ff;
   logic [OP_W-1:0]     in_op_ff;
   logic [PORT_W-1:0]   in_port_ff;
   logic [BYTE_W-1:0]   in_wdata_ff;

   // Result register.
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   out_rdata_ff;
   logic                out_level_ff;
   logic                out_speaker_ff;

   // Channel state.
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  reload_ff, reload_in;
   logic [COUNT_W-1:0]  latched_ff, latched_in;
   logic                square_ff, square_in;
   logic                wr_high_ff, wr_high_in;
   logic                latch_valid_ff, latch_valid_in;
   logic                rd_high_ff, rd_high_in;
   logic                gate_ff, gate_in;
   logic                spk_en_ff, spk_en_in;
   logic                out_ff, out_in;
   logic                active_ff, active_in;
   logic                trig_ff, trig_in;
   logic [BYTE_W-1:0]   rdata_in;

   logic                advance;
   logic                take;
   logic [1:0]          dec;
   logic [COUNT_W-1:0]  src;
   logic [COUNT_W-1:0]  count_minus1;

   // The item in the input register moves on when the result register frees.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign rsp_valid     = out_valid_ff;
   assign rsp_rdata     = out_rdata_ff;
   assign rsp_out_level = out_level_ff;
   assign rsp_speaker   = out_speaker_ff;

   // Square wave step: even counts drop by two; odd ones by one while high and three while low.
   always_comb begin
      if (count_ff[0]) begin
         dec = out_ff ? 2'd1 : 2'd3;
      end else begin
         dec = 2'd2;
      end
   end

   assign src          = latch_valid_ff ? latched_ff : count_ff;
   assign count_minus1 = count_ff - COUNT_W'(1);

   // Next state and result for the item in the input register.
   always_comb begin
      count_in       = count_ff;
      reload_in      = reload_ff;
      latched_in     = latched_ff;
      square_in      = square_ff;
      wr_high_in     = wr_high_ff;
      latch_valid_in = latch_valid_ff;
      rd_high_in     = rd_high_ff;
      gate_in        = gate_ff;
      spk_en_in      = spk_en_ff;
      out_in         = out_ff;
      active_in      = active_ff;
      trig_in        = trig_ff;
      rdata_in       = '0;
      unique case (in_op_ff)
         OP_TICK: begin
            if (square_ff) begin
               if (active_ff && gate_ff) begin
                  if (trig_ff) begin
                     count_in = reload_ff;
                     trig_in  = 1'b0;
                  end else if (count_ff != '0 && count_ff <= COUNT_W'(dec)) begin
                     // Count reaches or passes zero: toggle and reload.
                     out_in   = !out_ff;
                     count_in = reload_ff;
                  end else begin
                     count_in = count_ff - COUNT_W'(dec);
                  end
               end
            end else begin
               if (trig_ff) begin
                  count_in  = reload_ff;
                  out_in    = 1'b0;
                  active_in = 1'b1;
                  trig_in   = 1'b0;
               end else if (active_ff) begin
                  count_in = count_minus1;
                  if (count_minus1 == '0) begin
                     out_in = 1'b1;
                  end
               end
            end
         end
         OP_WRITE: begin
            unique case (in_port_ff)
               PORT_DATA: begin
                  if (!wr_high_ff) begin
                     reload_in  = {reload_ff[COUNT_W-1:BYTE_W], in_wdata_ff};
                     wr_high_in = 1'b1;
                  end else begin
                     reload_in  = {in_wdata_ff, reload_ff[BYTE_W-1:0]};
                     wr_high_in = 1'b0;
                     if (square_ff && !active_ff) begin
                        active_in = 1'b1;
                        trig_in   = 1'b1;
                     end
                  end
               end
               PORT_CTRL: begin
                  if (in_wdata_ff == CW_SQUARE || in_wdata_ff == CW_ONESHOT) begin
                     square_in      = (in_wdata_ff == CW_SQUARE);
                     wr_high_in     = 1'b0;
                     rd_high_in     = 1'b0;
                     latch_valid_in = 1'b0;
                     out_in         = 1'b1;
                     active_in      = 1'b0;
                     trig_in        = 1'b0;
                  end else if (in_wdata_ff == CW_LATCH && !latch_valid_ff) begin
                     latched_in     = count_ff;
                     latch_valid_in = 1'b1;
                  end
               end
               PORT_SYS: begin
                  spk_en_in = in_wdata_ff[SYS_SPK_BIT];
                  gate_in   = in_wdata_ff[SYS_GATE_BIT];
                  if (in_wdata_ff[SYS_GATE_BIT] && !gate_ff) begin
                     trig_in = 1'b1;
                  end
                  if (!in_wdata_ff[SYS_GATE_BIT] && gate_ff && square_ff) begin
                     out_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_READ: begin
            unique case (in_port_ff)
               PORT_DATA: begin
                  if (rd_high_ff) begin
                     rdata_in       = src[COUNT_W-1:BYTE_W];
                     latch_valid_in = 1'b0;
                  end else begin
                     rdata_in = src[BYTE_W-1:0];
                  end
                  rd_high_in = !rd_high_ff;
               end
               PORT_SYS: begin
                  rdata_in[SYS_GATE_BIT] = gate_ff;
                  rdata_in[SYS_SPK_BIT]  = spk_en_ff;
                  rdata_in[SYS_OUT_BIT]  = out_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Input register: loads on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (take) begin
         in_op_ff    <= req_op;
         in_port_ff  <= req_port;
         in_wdata_ff <= req_wdata;
      end
   end

   // Result register and channel state, updated as an item moves across.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         count_ff       <= '0;
         reload_ff      <= '0;
         latched_ff     <= '0;
         square_ff      <= 1'b1;
         wr_high_ff     <= 1'b0;
         latch_valid_ff <= 1'b0;
         rd_high_ff     <= 1'b0;
         gate_ff        <= 1'b0;
         spk_en_ff      <= 1'b0;
         out_ff         <= 1'b1;
         active_ff      <= 1'b0;
         trig_ff        <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff   <= 1'b1;
            count_ff       <= count_in;
            reload_ff      <= reload_in;
            latched_ff     <= latched_in;
            square_ff      <= square_in;
            wr_high_ff     <= wr_high_in;
            latch_valid_ff <= latch_valid_in;
            rd_high_ff     <= rd_high_in;
            gate_ff        <= gate_in;
            spk_en_ff      <= spk_en_in;
            out_ff         <= out_in;
            active_ff      <= active_in;
            trig_ff        <= trig_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_rdata_ff   <= rdata_in;
         out_level_ff   <= out_in;
         out_speaker_ff <= out_in && spk_en_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The result register never takes an item while it still holds a stalled one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("result overwritten while stalled");

   // A speaker result implies the output level is high.
   a_speaker_gated: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_speaker_ff) |-> out_level_ff)
      else $error("speaker high with output low");

   // Only bus reads return nonzero data.
   a_rdata_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff != OP_READ) |=> (out_rdata_ff == '0))
      else $error("nonzero read data for a non-read transfer");

   // A mode control word restarts the channel with the output high.
   a_ctrl_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_WRITE && in_port_ff == PORT_CTRL
       && (in_wdata_ff == CW_SQUARE || in_wdata_ff == CW_ONESHOT))
      |=> (out_ff && !active_ff && !trig_ff && !latch_valid_ff))
      else $error("control word did not restart the channel");
`endif

endmodule : interval_timer_counter_channel_core

// ===== bench/itcc_result_checker.sv =====
// ----------------------------------------------------------------------------
// Counter channel result checker
// Watches the request and result sides of the counter channel core. It keeps its own copy of
// the timer state, works out the result of every accepted request and
// compares it field by field with the results in the order they arrive.
// ----------------------------------------------------------------------------
module itcc_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [itcc_pkg::OP_W-1:0]     req_op,
   input  logic [itcc_pkg::PORT_W-1:0]   req_port,
   input  logic [itcc_pkg::BYTE_W-1:0]   req_wdata,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [itcc_pkg::BYTE_W-1:0]   rsp_rdata,
   input  logic                          rsp_out_level,
   input  logic                          rsp_speaker,
   output int                            mismatch_total,
   output int                            results_pending,
   output int                            results_checked
);
   import itcc_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] rdata;
      logic              out_level;
      logic              speaker;
   } timer_result_type;

   // Results still owed by the core, oldest first.
   timer_result_type owed_results[$];

   // Shadow copy of the counter channel.
   logic [COUNT_W-1:0] count_now;
   logic [COUNT_W-1:0] reload_word;
   logic               square_mode;
   logic               load_high_byte;
   logic [COUNT_W-1:0] latched_word;
   logic               latch_held;
   logic               read_high_byte;
   logic               gate_q;
   logic               speaker_on;
   logic               out_q;
   logic               running;
   logic               load_armed;

   int mismatches;
   int checked;

   always @(posedge clock) begin
      timer_result_type   got;
      timer_result_type   want;
      logic [BYTE_W-1:0]  rd;
      logic [1:0]         step;
      logic [COUNT_W:0]   span;
      logic [COUNT_W-1:0] source;

      if (reset) begin
         count_now      = '0;
         reload_word    = '0;
         square_mode    = 1'b1;
         load_high_byte = 1'b0;
         latched_word   = '0;
         latch_held     = 1'b0;
         read_high_byte = 1'b0;
         gate_q         = 1'b0;
         speaker_on     = 1'b0;
         out_q          = 1'b1;
         running        = 1'b0;
         load_armed     = 1'b0;
         mismatches     = 0;
         checked        = 0;
         owed_results.delete();
      end else begin
         // Compare a result transfer with the oldest owed result.
         if (rsp_valid && !rsp_stall) begin
            got = '{rdata: rsp_rdata, out_level: rsp_out_level, speaker: rsp_speaker};
            if (owed_results.size() == 0) begin
               if (mismatches < 10)
                  $display("[%0t] unexpected result: rdata %02h out %0b spk %0b",
                           $time, got.rdata, got.out_level, got.speaker);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display({"[%0t] result %0d mismatch: expected rdata %02h out %0b ",
                               "spk %0b, got rdata %02h out %0b spk %0b"},
                              $time, checked, want.rdata, want.out_level, want.speaker,
                              got.rdata, got.out_level, got.speaker);
                  mismatches++;
               end
               checked++;
            end
         end

         // Advance the shadow channel by one request transfer.
         if (req_valid && !req_stall) begin
            rd = '0;
            case (req_op)
               OP_TICK: begin
                  if (square_mode) begin
                     // Square wave: idle without a full count or with the gate low.
                     if (running && gate_q) begin
                        if (load_armed) begin
                           count_now  = reload_word;
                           load_armed = 1'b0;
                        end else begin
                           // Even counts lose two; odd ones lose one while high and three while low.
                           step = 2'd2;
                           if (count_now[0])
                              step = out_q ? 2'd1 : 2'd3;
                           span = (count_now == '0) ? {1'b1, {COUNT_W{1'b0}}}
                                                    : {1'b0, count_now};
                           if (span <= (COUNT_W+1)'(step)) begin
                              out_q     = ~out_q;
                              count_now = reload_word;
                           end else begin
                              count_now = COUNT_W'(span - (COUNT_W+1)'(step));
                           end
                        end
                     end
                  end else begin
                     // One-shot: a trigger loads and drops the output, zero raises it.
                     if (load_armed) begin
                        count_now  = reload_word;
                        out_q      = 1'b0;
                        running    = 1'b1;
                        load_armed = 1'b0;
                     end else if (running) begin
                        count_now = count_now - COUNT_W'(1);
                        if (count_now == '0)
                           out_q = 1'b1;
                     end
                  end
               end
               OP_WRITE: begin
                  case (req_port)
                     PORT_DATA: begin
                        if (!load_high_byte) begin
                           reload_word[7:0] = req_wdata;
                           load_high_byte   = 1'b1;
                        end else begin
                           reload_word[15:8] = req_wdata;
                           load_high_byte    = 1'b0;
                           if (square_mode && !running) begin
                              running    = 1'b1;
                              load_armed = 1'b1;
                           end
                        end
                     end
                     PORT_CTRL: begin
                        if (req_wdata == CW_SQUARE || req_wdata == CW_ONESHOT) begin
                           square_mode    = (req_wdata == CW_SQUARE);
                           load_high_byte = 1'b0;
                           read_high_byte = 1'b0;
                           latch_held     = 1'b0;
                           out_q          = 1'b1;
                           running        = 1'b0;
                           load_armed     = 1'b0;
                        end else if (req_wdata == CW_LATCH && !latch_held) begin
                           latched_word = count_now;
                           latch_held   = 1'b1;
                        end
                     end
                     PORT_SYS: begin
                        speaker_on = req_wdata[SYS_SPK_BIT];
                        if (req_wdata[SYS_GATE_BIT] && !gate_q)
                           load_armed = 1'b1;
                        if (!req_wdata[SYS_GATE_BIT] && gate_q && square_mode)
                           out_q = 1'b1;
                        gate_q = req_wdata[SYS_GATE_BIT];
                     end
                     default: ;
                  endcase
               end
               OP_READ: begin
                  case (req_port)
                     PORT_DATA: begin
                        source = latch_held ? latched_word : count_now;
                        if (read_high_byte) begin
                           rd         = source[15:8];
                           latch_held = 1'b0;
                        end else begin
                           rd = source[7:0];
                        end
                        read_high_byte = ~read_high_byte;
                     end
                     PORT_SYS: begin
                        rd[SYS_GATE_BIT] = gate_q;
                        rd[SYS_SPK_BIT]  = speaker_on;
                        rd[SYS_OUT_BIT]  = out_q;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
            owed_results.push_back('{rdata: rd, out_level: out_q,
                                     speaker: out_q & speaker_on});
         end
      end

      mismatch_total  <= mismatches;
      results_pending <= owed_results.size();
      results_checked <= checked;
   end

endmodule : itcc_result_checker

// ===== bench/tb_interval_timer_counter_channel_core.sv =====
// ----------------------------------------------------------------------------
// Counter channel core testbench
// Drives ticks, bus writes and bus reads into the counter channel core: a
// short directed opening, then random mode, count and gate sequences mixed
// with noise, under phases of sender gaps and receiver stalls. The result
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_interval_timer_counter_channel_core ();
   import itcc_pkg::*;

   // Item and port codes that the core does not use.
   localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
   localparam logic [PORT_W-1:0] PORT_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1900;
   localparam int PHASE_ITEMS    = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef enum int {
      PH_STEADY,
      PH_SENDER_IDLE,
      PH_RECEIVER_STALL,
      PH_BOTH_IDLE
   } idle_phase_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_op        = OP_TICK;
   logic [PORT_W-1:0]   req_port      = PORT_DATA;
   logic [BYTE_W-1:0]   req_wdata     = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [BYTE_W-1:0]   rsp_rdata;
   logic                rsp_out_level;
   logic                rsp_speaker;

   int             mismatch_total;
   int             results_pending;
   int             results_checked;
   idle_phase_type idle_phase = PH_STEADY;
   int             quiet_cycles;
   int             items_sent;
   int             ticks_sent;
   int             writes_sent;
   int             reads_sent;
   int             unused_sent;

   interval_timer_counter_channel_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_port      (req_port),
      .req_wdata     (req_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rdata     (rsp_rdata),
      .rsp_out_level (rsp_out_level),
      .rsp_speaker   (rsp_speaker)
   );

   itcc_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_port        (req_port),
      .req_wdata       (req_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rdata       (rsp_rdata),
      .rsp_out_level   (rsp_out_level),
      .rsp_speaker     (rsp_speaker),
      .mismatch_total  (mismatch_total),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // True in pct cases of a hundred.
   function automatic bit roll(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Receiver side: random stalls according to the current phase.
   always @(negedge clock) begin
      case (idle_phase)
         PH_RECEIVER_STALL: rsp_stall <= roll(85);
         PH_BOTH_IDLE:      rsp_stall <= roll(9);
         default:           rsp_stall <= 1'b0;
      endcase
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request, with random gaps before it, and wait for its transfer.
   // Called and returning at a falling edge.
   task automatic issue_item(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                             input logic [BYTE_W-1:0] wdata);
      int gap_rate;

      gap_rate = (idle_phase == PH_SENDER_IDLE) ? 85 :
                 (idle_phase == PH_BOTH_IDLE)   ? 9  : 0;
      while (roll(gap_rate)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_port  <= port;
      req_wdata <= wdata;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
      case (op)
         OP_TICK:  ticks_sent++;
         OP_WRITE: writes_sent++;
         OP_READ:  reads_sent++;
         default:  unused_sent++;
      endcase
   endtask

   // Latch the count and read both latched bytes.
   task automatic latch_and_read();
      issue_item(OP_WRITE, PORT_CTRL, CW_LATCH);
      issue_item(OP_READ, PORT_DATA, BYTE_W'($urandom_range(255)));
      issue_item(OP_READ, PORT_DATA, BYTE_W'($urandom_range(255)));
   endtask

   initial begin
      logic [COUNT_W-1:0] count_word;
      logic [BYTE_W-1:0]  sys_byte;
      int                 random_start;
      int                 pick;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed opening: reset values, unused codes and ignored words.
      issue_item(OP_READ, PORT_SYS, 8'h00);
      issue_item(OP_READ, PORT_DATA, 8'hff);
      issue_item(OP_TICK, PORT_DATA, 8'h00);
      issue_item(OP_WRITE, PORT_CTRL, 8'h36);
      issue_item(OP_READ, PORT_CTRL, 8'h00);
      issue_item(OP_UNUSED, PORT_UNUSED, 8'hff);

      // Square wave with a count of one, then a double latch and a gate fall.
      issue_item(OP_WRITE, PORT_CTRL, CW_SQUARE);
      issue_item(OP_WRITE, PORT_DATA, 8'h01);
      issue_item(OP_WRITE, PORT_DATA, 8'h00);
      issue_item(OP_WRITE, PORT_SYS, 8'h03);
      repeat (3) issue_item(OP_TICK, PORT_DATA, 8'h00);
      issue_item(OP_WRITE, PORT_CTRL, CW_LATCH);
      latch_and_read();
      issue_item(OP_WRITE, PORT_SYS, 8'h02);

      // One-shot triggered on a half-written count.
      issue_item(OP_WRITE, PORT_CTRL, CW_ONESHOT);
      issue_item(OP_WRITE, PORT_DATA, 8'hff);
      issue_item(OP_WRITE, PORT_SYS, 8'h01);
      repeat (2) issue_item(OP_TICK, PORT_DATA, 8'h00);

      // Square wave with a count of zero, meaning the full range.
      issue_item(OP_WRITE, PORT_CTRL, CW_SQUARE);
      issue_item(OP_WRITE, PORT_DATA, 8'h00);
      issue_item(OP_WRITE, PORT_DATA, 8'h00);
      repeat (2) issue_item(OP_TICK, PORT_DATA, 8'h00);

      // Random part: mostly well-formed programming sequences, some noise.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         idle_phase = idle_phase_type'(((items_sent - random_start) / PHASE_ITEMS) % 4);
         if (roll(15)) begin
            repeat ($urandom_range(1, 6))
               issue_item(OP_W'($urandom_range(3)), PORT_W'($urandom_range(3)),
                          BYTE_W'($urandom_range(255)));
         end else begin
            issue_item(OP_WRITE, PORT_CTRL, roll(55) ? CW_SQUARE : CW_ONESHOT);
            count_word = roll(85) ? COUNT_W'($urandom_range(1, 24))
                                  : COUNT_W'($urandom_range(16'hffff));
            issue_item(OP_WRITE, PORT_DATA, count_word[7:0]);
            if (!roll(8))
               issue_item(OP_WRITE, PORT_DATA, count_word[15:8]);

            // Gate low then high, so that the sequence starts on a rising edge.
            sys_byte = BYTE_W'($urandom_range(255));
            sys_byte[SYS_GATE_BIT] = 1'b0;
            issue_item(OP_WRITE, PORT_SYS, sys_byte);
            sys_byte[SYS_GATE_BIT] = 1'b1;
            issue_item(OP_WRITE, PORT_SYS, sys_byte);

            repeat ($urandom_range(10, 40)) begin
               pick = int'($urandom_range(99));
               if (pick < 68)
                  issue_item(OP_TICK, PORT_W'($urandom_range(3)),
                             BYTE_W'($urandom_range(255)));
               else if (pick < 76)
                  latch_and_read();
               else if (pick < 82)
                  issue_item(OP_READ, PORT_DATA, BYTE_W'($urandom_range(255)));
               else if (pick < 88)
                  issue_item(OP_READ, PORT_SYS, BYTE_W'($urandom_range(255)));
               else if (pick < 95)
                  issue_item(OP_WRITE, PORT_SYS, BYTE_W'($urandom_range(255)));
               else
                  issue_item(OP_WRITE, PORT_DATA, BYTE_W'($urandom_range(255)));
            end
         end
      end
      req_valid <= 1'b0;

      // Drain the owed results, then let the pipeline settle.
      while (results_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d ticks, %0d bus writes, %0d bus reads, %0d unused codes.",
               ticks_sent, writes_sent, reads_sent, unused_sent);
      $display("%0d results checked across steady, gap and stall phases; %0d mismatched.",
               results_checked, mismatch_total);
      if (mismatch_total == 0 && results_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule : tb_interval_timer_counter_channel_core

// ===== filelist.f =====
rtl/core/itcc_pkg.sv
rtl/core/interval_timer_counter_channel_core.sv
bench/itcc_result_checker.sv
bench/tb_interval_timer_counter_channel_core.sv
